// ===== hw/rtl/lsb_pkg.sv =====
// shared constants, types and state codes of the lcd shadow buffer refresh block
`default_nettype none
package lsb_pkg;

    localparam int LSB_COLUMNS = 16;
    localparam int LSB_ROWS    = 2;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] ADDR_CMD   = 8'h80;
    localparam logic [7:0] ROW_STRIDE = 8'h40;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_WAIT,
        ST_WR_CMP,
        ST_SCAN,
        ST_RD_WAIT,
        ST_EMIT_CMD,
        ST_EMIT_DATA
    } t_back_state;

endpackage
`default_nettype wire

// ===== hw/rtl/lcd_shadow_buffer_refresh.sv =====
// top level of the character lcd shadow buffer with dirty-cell refresh
// Items enter a two-deep queue and are carried out one at a time by the back
// unit. A write goes through dequeue, store read, then compare and write, and
// produces no bytes. A refresh tick is dequeued and then scans one cell per
// cycle, examining at most COLUMNS*ROWS+1 cells (32+1 by default) when
// nothing is dirty; a dirty cell adds a store read and then its emitted bytes
// (the address command when the cell does not follow the last written one,
// then the data byte marked last), each sent when the result queue has room.
// Emitted bytes wait in a two-deep result queue. The store comes out of
// reset reading as spaces with no dirty marks at once, with no clearing pass.
`default_nettype none
module lcd_shadow_buffer_refresh #(
    parameter int COLUMNS = lsb_pkg::LSB_COLUMNS,
    parameter int ROWS    = lsb_pkg::LSB_ROWS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_cmd,
    input  wire logic [3:0] i_column,
    input  wire logic       i_row,
    input  wire logic [7:0] i_character,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      o_lcd_byte,
    output logic            o_is_data,
    output logic            o_last
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int OP_W  = 1 + IDX_W + 8;
    localparam int RES_W = $bits(lsb_pkg::t_result);

    logic             op_push;
    logic             op_tick_in;
    logic [IDX_W-1:0] op_idx_in;
    logic [7:0]       op_char_in;
    logic             op_full;
    logic             op_pop;
    logic             op_empty;
    logic [OP_W-1:0]  op_data;

    logic             res_push;
    logic             res_full;
    lsb_pkg::t_result res_in;
    lsb_pkg::t_result res_out;

    lsb_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .IDX_W   (IDX_W)
    ) u_front (
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (i_cmd),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_character (i_character),
        .o_op_push   (op_push),
        .o_op_tick   (op_tick_in),
        .o_op_idx    (op_idx_in),
        .o_op_char   (op_char_in),
        .i_op_full   (op_full)
    );

    lsb_fifo #(
        .WIDTH (OP_W),
        .DEPTH (2)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  ({op_tick_in, op_idx_in, op_char_in}),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (op_data),
        .o_empty (op_empty)
    );

    lsb_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .IDX_W   (IDX_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (op_empty),
        .i_op_tick  (op_data[OP_W-1]),
        .i_op_idx   (op_data[OP_W-2:8]),
        .i_op_char  (op_data[7:0]),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    lsb_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_lcd_byte = res_out.lcd_byte;
    assign o_is_data  = res_out.is_data;
    assign o_last     = res_out.last;

endmodule
`default_nettype wire

// ===== hw/rtl/lsb_fifo.sv =====
// small register queue between the front, the back and the result side
`default_nettype none
module lsb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lsb_front.sv =====
// front end: accepts items, drops writes outside the screen, forms the cell index
`default_nettype none
module lsb_front #(
    parameter int COLUMNS = lsb_pkg::LSB_COLUMNS,
    parameter int ROWS    = lsb_pkg::LSB_ROWS,
    parameter int IDX_W   = 5
) (
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic             i_cmd,
    input  wire logic [3:0]       i_column,
    input  wire logic             i_row,
    input  wire logic [7:0]       i_character,
    output logic                  o_op_push,
    output logic                  o_op_tick,
    output logic [IDX_W-1:0]      o_op_idx,
    output logic [7:0]            o_op_char,
    input  wire logic             i_op_full
);

    logic in_range;

    always_comb begin
        in_range  = ({28'd0, i_column} < 32'(COLUMNS)) && ({31'd0, i_row} < 32'(ROWS));
        o_full    = i_op_full;
        o_op_tick = (i_cmd == lsb_pkg::CMD_TICK);
        o_op_idx  = i_row ? IDX_W'(COLUMNS) + IDX_W'(i_column) : IDX_W'(i_column);
        o_op_char = i_character;
        // out-of-range writes are taken and dropped here
        o_op_push = i_push && !i_op_full && (o_op_tick || in_range);
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lsb_back.sv =====
// back end: shadow store, dirty marks, refresh scanner and byte emission
`default_nettype none
module lsb_back #(
    parameter int COLUMNS = lsb_pkg::LSB_COLUMNS,
    parameter int ROWS    = lsb_pkg::LSB_ROWS,
    parameter int IDX_W   = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_op_empty,
    input  wire logic             i_op_tick,
    input  wire logic [IDX_W-1:0] i_op_idx,
    input  wire logic [7:0]       i_op_char,
    output logic                  o_op_pop,
    input  wire logic             i_res_full,
    output logic                  o_res_push,
    output lsb_pkg::t_result      o_res
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int SCOL_W = $clog2(COLUMNS + 1);

    lsb_pkg::t_back_state r_state, n_state;

    logic [7:0]        r_mem [CELLS];
    logic [CELLS-1:0]  r_written;
    logic [CELLS-1:0]  r_dirty;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [7:0]        r_char, n_char;
    logic [7:0]        r_rdata;
    logic [SCOL_W-1:0] r_scan_col, n_scan_col;
    logic              r_scan_row, n_scan_row;
    logic [SCOL_W-1:0] r_exp_col, n_exp_col;
    logic              r_exp_valid, n_exp_valid;
    logic              r_need_addr, n_need_addr;
    logic [7:0]        r_cmd_byte, n_cmd_byte;

    logic              wr_en;
    logic              dirty_set;
    logic              dirty_clr;
    logic [SCOL_W-1:0] cur_col;
    logic              cur_row;
    logic              cur_ev;
    logic              wrapped;
    logic [IDX_W-1:0]  scan_idx;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_char      = r_char;
        n_scan_col  = r_scan_col;
        n_scan_row  = r_scan_row;
        n_exp_col   = r_exp_col;
        n_exp_valid = r_exp_valid;
        n_need_addr = r_need_addr;
        n_cmd_byte  = r_cmd_byte;
        o_op_pop    = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        wr_en       = 1'b0;
        dirty_set   = 1'b0;
        dirty_clr   = 1'b0;

        // next cell of the scan, with the row step and wrap folded in
        cur_col = r_scan_col;
        cur_row = r_scan_row;
        cur_ev  = r_exp_valid;
        wrapped = 1'b0;
        if (r_scan_col >= SCOL_W'(COLUMNS)) begin
            cur_col = '0;
            cur_ev  = 1'b0;
            if (r_scan_row == 1'(ROWS - 1)) begin
                cur_row = 1'b0;
                wrapped = 1'b1;
            end else begin
                cur_row = 1'b1;
            end
        end
        scan_idx = cur_row ? IDX_W'(COLUMNS) + IDX_W'(cur_col) : IDX_W'(cur_col);

        unique case (r_state)
            lsb_pkg::ST_IDLE: begin
                if (!i_op_empty) begin
                    o_op_pop = 1'b1;
                    if (i_op_tick) begin
                        n_state = lsb_pkg::ST_SCAN;
                    end else begin
                        n_addr  = i_op_idx;
                        n_char  = i_op_char;
                        n_state = lsb_pkg::ST_WR_WAIT;
                    end
                end
            end
            lsb_pkg::ST_WR_WAIT: begin
                n_state = lsb_pkg::ST_WR_CMP;
            end
            lsb_pkg::ST_WR_CMP: begin
                if (r_rdata != r_char) begin
                    wr_en     = 1'b1;
                    dirty_set = 1'b1;
                end
                n_state = lsb_pkg::ST_IDLE;
            end
            lsb_pkg::ST_SCAN: begin
                n_scan_row = cur_row;
                n_scan_col = cur_col + 1'b1;
                if (r_dirty[scan_idx]) begin
                    n_addr      = scan_idx;
                    n_need_addr = !(cur_ev && (r_exp_col == cur_col));
                    n_cmd_byte  = lsb_pkg::ADDR_CMD |
                                  ((cur_row ? lsb_pkg::ROW_STRIDE : 8'h00) + 8'(cur_col));
                    n_exp_col   = cur_col + 1'b1;
                    n_exp_valid = 1'b1;
                    n_state     = lsb_pkg::ST_RD_WAIT;
                end else begin
                    n_exp_valid = cur_ev;
                    if (wrapped) begin
                        n_state = lsb_pkg::ST_IDLE;
                    end
                end
            end
            lsb_pkg::ST_RD_WAIT: begin
                dirty_clr = 1'b1;
                n_state   = r_need_addr ? lsb_pkg::ST_EMIT_CMD : lsb_pkg::ST_EMIT_DATA;
            end
            lsb_pkg::ST_EMIT_CMD: begin
                o_res.lcd_byte = r_cmd_byte;
                o_res.is_data  = 1'b0;
                o_res.last     = 1'b0;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = lsb_pkg::ST_EMIT_DATA;
                end
            end
            lsb_pkg::ST_EMIT_DATA: begin
                o_res.lcd_byte = r_rdata;
                o_res.is_data  = 1'b1;
                o_res.last     = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = lsb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsb_pkg::ST_IDLE;
            r_written   <= '0;
            r_dirty     <= '0;
            r_scan_col  <= '0;
            r_scan_row  <= 1'b0;
            r_exp_col   <= '0;
            r_exp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_col  <= n_scan_col;
            r_scan_row  <= n_scan_row;
            r_exp_col   <= n_exp_col;
            r_exp_valid <= n_exp_valid;
            if (wr_en) begin
                r_written[r_addr] <= 1'b1;
            end
            if (dirty_set) begin
                r_dirty[r_addr] <= 1'b1;
            end else if (dirty_clr) begin
                r_dirty[r_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_char      <= n_char;
        r_need_addr <= n_need_addr;
        r_cmd_byte  <= n_cmd_byte;
    end

    // cells never written read as space
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= r_char;
        end
        r_rdata <= r_written[r_addr] ? r_mem[r_addr] : lsb_pkg::SPACE_CHAR;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lsb_checker.sv =====
// port-level checks of the lcd shadow buffer refresh block and their binding
`default_nettype none
module lsb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       pop,
    input wire logic       empty,
    input wire logic [7:0] o_lcd_byte,
    input wire logic       o_is_data,
    input wire logic       o_last
);

    // address commands always carry the set-address opcode bit and never end a tick
    a_cmd_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_is_data) |-> (o_lcd_byte[7] && !o_last))
        else $error("address command malformed");

    // every data byte closes its tick
    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_data) |-> o_last)
        else $error("data byte not marked last");

    // after a command byte is taken, the next waiting item, if any, is a data byte
    a_cmd_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_is_data) |=> (empty || o_is_data))
        else $error("command byte not followed by data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable({o_lcd_byte, o_is_data, o_last})))
        else $error("waiting item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

bind lcd_shadow_buffer_refresh lsb_checker u_lsb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .pop        (pop),
    .empty      (empty),
    .o_lcd_byte (o_lcd_byte),
    .o_is_data  (o_is_data),
    .o_last     (o_last)
);
`default_nettype wire

// ===== dv/lcd_shadow_buffer_refresh_test.sv =====
// testbench for the lcd shadow buffer refresh block: writes and ticks checked on a cell model
module lcd_shadow_buffer_refresh_test;
    import lsb_pkg::*;

    localparam int COLS  = LSB_COLUMNS;
    localparam int ROWS  = LSB_ROWS;
    localparam int CELLS = COLS * ROWS;
    localparam int RANDOM_ITEMS = 700;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_STALL
    } t_rx_mode;

    class refresh_tracker;
        logic [7:0] shadow_char [CELLS];
        bit         shadow_dirty [CELLS];
        int         scan_col;
        int         scan_row;
        int         follow_col;
        bit         follow_valid;
        t_result    pending_bytes [$];
        int         failures;

        function new();
            for (int i = 0; i < CELLS; i++) begin
                shadow_char[i]  = SPACE_CHAR;
                shadow_dirty[i] = 1'b0;
            end
            scan_col     = 0;
            scan_row     = 0;
            follow_col   = 0;
            follow_valid = 1'b0;
            failures     = 0;
        endfunction

        function void predict_tick();
            bit      done;
            int      idx;
            t_result r;
            done = 1'b0;
            for (int guard = 0; guard < CELLS + 2 && !done; guard++) begin
                if (scan_col >= COLS) begin
                    scan_col = 0;
                    scan_row++;
                    follow_valid = 1'b0;
                    if (scan_row >= ROWS) begin
                        scan_row = 0;
                        done = 1'b1;
                    end
                end
                if (scan_row >= ROWS) begin
                    scan_row = 0;
                end
                idx = scan_row * COLS + scan_col;
                if (shadow_dirty[idx]) begin
                    if (!(follow_valid && follow_col == scan_col)) begin
                        r.lcd_byte = 8'(scan_row * ROW_STRIDE + scan_col) | ADDR_CMD;
                        r.is_data  = 1'b0;
                        r.last     = 1'b0;
                        pending_bytes.push_back(r);
                    end
                    r.lcd_byte = shadow_char[idx];
                    r.is_data  = 1'b1;
                    r.last     = 1'b1;
                    pending_bytes.push_back(r);
                    shadow_dirty[idx] = 1'b0;
                    follow_col   = scan_col + 1;
                    follow_valid = 1'b1;
                    done = 1'b1;
                end
                scan_col++;
            end
        endfunction

        function void note_item(logic cmd, logic [3:0] col, logic row, logic [7:0] ch);
            int idx;
            if (cmd == CMD_WRITE) begin
                if (int'(col) < COLS && int'(row) < ROWS) begin
                    idx = int'(row) * COLS + int'(col);
                    if (shadow_char[idx] != ch) begin
                        shadow_char[idx]  = ch;
                        shadow_dirty[idx] = 1'b1;
                    end
                end
            end else begin
                predict_tick();
            end
        endfunction

        function void check_byte(logic [7:0] lcd_byte, logic is_data, logic last);
            t_result exp_r;
            if (pending_bytes.size() == 0) begin
                $error("unexpected byte %h (is_data %b, last %b)", lcd_byte, is_data, last);
                failures++;
                return;
            end
            exp_r = pending_bytes.pop_front();
            if (lcd_byte !== exp_r.lcd_byte) begin
                $error("lcd_byte: expected %h, got %h", exp_r.lcd_byte, lcd_byte);
                failures++;
            end
            if (is_data !== exp_r.is_data) begin
                $error("is_data: expected %b, got %b", exp_r.is_data, is_data);
                failures++;
            end
            if (last !== exp_r.last) begin
                $error("last: expected %b, got %b", exp_r.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       i_cmd       = CMD_WRITE;
    logic [3:0] i_column    = 4'd0;
    logic       i_row       = 1'b0;
    logic [7:0] i_character = 8'd0;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_lcd_byte;
    logic       o_is_data;
    logic       o_last;

    refresh_tracker sb;
    int       burst_left = 0;
    int       items_sent = 0;
    t_rx_mode rx_mode    = RX_FREE;
    int       rx_left    = 0;
    logic [7:0] rx_phase = 8'd0;

    lcd_shadow_buffer_refresh dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_character (i_character),
        .pop         (pop),
        .empty       (empty),
        .o_lcd_byte  (o_lcd_byte),
        .o_is_data   (o_is_data),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                sb.note_item(i_cmd, i_column, i_row, i_character);
            end
            if (pop && !empty) begin
                sb.check_byte(o_lcd_byte, o_is_data, o_last);
            end
        end
    end

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(10, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:   pop <= 1'b1;
            RX_COIN:   pop <= 1'($urandom_range(0, 1));
            RX_SPARSE: pop <= (rx_phase[1:0] == 2'd0);
            default:   pop <= (int'(rx_phase) % 24 >= 20);
        endcase
    end

    task automatic send_item(input logic cmd, input logic [3:0] col, input logic row,
                             input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                push        <= 1'b0;
                i_cmd       <= 1'($urandom_range(0, 1));
                i_column    <= 4'($urandom_range(0, 15));
                i_row       <= 1'($urandom_range(0, 1));
                i_character <= 8'($urandom_range(0, 255));
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        push        <= 1'b1;
        i_cmd       <= cmd;
        i_column    <= col;
        i_row       <= row;
        i_character <= ch;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic write_cell(input int col, input int row, input logic [7:0] ch);
        send_item(CMD_WRITE, 4'(col), 1'(row), ch);
    endtask

    task automatic tick();
        send_item(CMD_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    endtask

    initial begin
        int mode;
        int row;
        int col;
        int len;
        int idx;
        logic [7:0] ch;

        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing dirty, then a rewrite of the same character
        tick();
        write_cell(0, 0, SPACE_CHAR);
        tick();
        // origin found only after the wrap
        write_cell(0, 0, 8'h00);
        tick();
        // contiguous run, then a row change
        write_cell(14, 0, 8'h41);
        write_cell(15, 0, 8'h42);
        write_cell(0, 1, 8'h43);
        write_cell(15, 1, 8'hFF);
        repeat (4) tick();
        write_cell(3, 1, 8'h55);
        write_cell(4, 1, 8'hAA);
        write_cell(3, 1, 8'h55);
        repeat (3) tick();
        // mark stays when the cell is written back to its old value
        write_cell(7, 0, 8'h31);
        write_cell(7, 0, SPACE_CHAR);
        repeat (2) tick();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            if (mode <= 4) begin
                row = $urandom_range(0, ROWS - 1);
                col = $urandom_range(0, COLS - 1);
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    idx = (row * COLS + col + k) % CELLS;
                    ch = ($urandom_range(0, 5) == 0) ? sb.shadow_char[idx]
                                                     : 8'($urandom_range(0, 255));
                    write_cell(idx % COLS, idx / COLS, ch);
                end
                repeat ($urandom_range(0, len + 2)) tick();
            end else if (mode <= 6) begin
                ch = ($urandom_range(0, 3) == 0) ? SPACE_CHAR : 8'($urandom_range(0, 255));
                write_cell($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1), ch);
            end else if (mode <= 8) begin
                repeat ($urandom_range(1, 4)) tick();
            end else begin
                idx = $urandom_range(0, CELLS - 1);
                write_cell(idx % COLS, idx / COLS, sb.shadow_char[idx]);
                tick();
            end
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
